>>> src/psm_pkg.sv
// ---------------------------------------------------------------------------
// psm_pkg: shared types and constants of the p-code stack machine
// Opcodes, operator codes, fault codes and the divider status struct.
// ---------------------------------------------------------------------------
`default_nettype none
package psm_pkg;

  localparam int WORD_W = 32;

  localparam logic [2:0] MODE_LIT = 3'd0;
  localparam logic [2:0] MODE_OPR = 3'd1;
  localparam logic [2:0] MODE_LOD = 3'd2;
  localparam logic [2:0] MODE_STO = 3'd3;
  localparam logic [2:0] MODE_CAL = 3'd4;
  localparam logic [2:0] MODE_INT = 3'd5;
  localparam logic [2:0] MODE_JMP = 3'd6;
  localparam logic [2:0] MODE_JPC = 3'd7;

  localparam logic [10:0] OPR_RET = 11'd0;
  localparam logic [10:0] OPR_NEG = 11'd1;
  localparam logic [10:0] OPR_ADD = 11'd2;
  localparam logic [10:0] OPR_SUB = 11'd3;
  localparam logic [10:0] OPR_MUL = 11'd4;
  localparam logic [10:0] OPR_DIV = 11'd5;
  localparam logic [10:0] OPR_ODD = 11'd6;
  localparam logic [10:0] OPR_EQ  = 11'd8;
  localparam logic [10:0] OPR_NE  = 11'd9;
  localparam logic [10:0] OPR_LT  = 11'd10;
  localparam logic [10:0] OPR_GE  = 11'd11;
  localparam logic [10:0] OPR_GT  = 11'd12;
  localparam logic [10:0] OPR_LE  = 11'd13;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_DIV0  = 2'd1;
  localparam logic [1:0] FAULT_STACK = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

>>> src/psm_stack_mem.sv
// ---------------------------------------------------------------------------
// psm_stack_mem: word stack memory
// One write port, one registered read port, and a clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none
module psm_stack_mem #(
  parameter int STACK_DEPTH = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           we,
  input  wire logic [$clog2(STACK_DEPTH)-1:0] waddr,
  input  wire logic [psm_pkg::WORD_W-1:0]     wdata,
  input  wire logic                           re,
  input  wire logic [$clog2(STACK_DEPTH)-1:0] raddr,
  output logic      [psm_pkg::WORD_W-1:0]     rdata,
  output logic                                busy
);
  localparam int SW = $clog2(STACK_DEPTH);

  logic [psm_pkg::WORD_W-1:0] mem [STACK_DEPTH];
  logic [SW-1:0]              clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == SW'(STACK_DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> src/psm_div.sv
// ---------------------------------------------------------------------------
// psm_div: unsigned restoring divider
// One quotient bit per cycle; done pulses as the last quotient bit is registered.
// ---------------------------------------------------------------------------
`default_nettype none
module psm_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [psm_pkg::WORD_W-1:0] dividend,
  input  wire logic [psm_pkg::WORD_W-1:0] divisor,
  output logic      [psm_pkg::WORD_W-1:0] quotient,
  output psm_pkg::div_stat_t              stat
);
  localparam int W  = psm_pkg::WORD_W;
  localparam int CW = $clog2(W) + 1;

  logic [W-1:0]  rem;
  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;

  assign rem_sh = {rem, quotient[W-1]};
  assign diff   = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        quotient  <= dividend;
        rem       <= '0;
        dsr       <= divisor;
        cnt       <= CW'(W);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        if (!diff[W]) begin
          rem      <= diff[W-1:0];
          quotient <= {quotient[W-2:0], 1'b1};
        end else begin
          rem      <= rem_sh[W-1:0];
          quotient <= {quotient[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> src/pcode_stack_machine_step.sv
// ---------------------------------------------------------------------------
// pcode_stack_machine_step: PL/0 p-code machine, one instruction per transfer
// Each static level walked and a divide lengthen an instruction. One
// instruction is in flight at a time, and the next transfer is taken in the
// cycle after the result is registered; an instruction lasts longer while its
// result waits for the receiver. After reset a clearing pass zeroes the stack
// before the first instruction is taken. The user must keep PROGRAM_WORDS a
// power of two; the block does not enforce it.
// ---------------------------------------------------------------------------
`default_nettype none
module pcode_stack_machine_step #(
  parameter int STACK_DEPTH   = 4096,
  parameter int MAX_LEVEL     = 3,
  parameter int PROGRAM_WORDS = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // mode[2:0], level[4:3], operand[15:5]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // next_pc[10:0], top_index[23:11], base_index[35:24], top_value[67:36],
  // halted[68], fault[70:69], zero[71]
  output logic [71:0]      m_tdata
);
  localparam int W  = psm_pkg::WORD_W;
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(PROGRAM_WORDS);
  localparam int IW = 34;
  localparam logic signed [IW-1:0] DEPTH_S = IW'(STACK_DEPTH);

  typedef enum logic [14:0] {
    S_CLEAR = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_WALK  = 15'b000000000000100,
    S_WALKW = 15'b000000000001000,
    S_EXEC  = 15'b000000000010000,
    S_RD0   = 15'b000000000100000,
    S_RD1   = 15'b000000001000000,
    S_RD2   = 15'b000000010000000,
    S_ALU   = 15'b000000100000000,
    S_DIVW  = 15'b000001000000000,
    S_WR    = 15'b000010000000000,
    S_FAULT = 15'b000100000000000,
    S_TOP   = 15'b001000000000000,
    S_TOPW  = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_t;

  function automatic logic ix_ok(input logic signed [IW-1:0] i);
    return (i >= 0) && (i < DEPTH_S);
  endfunction

  state_t                 state;
  logic [2:0]             mode;
  logic [10:0]            opa;
  logic [3:0]             lvl_cnt;
  logic signed [SW:0]     top;
  logic [SW-1:0]          base;
  logic [PW-1:0]          pc;
  logic signed [IW-1:0]   bl;
  logic [W-1:0]           x;
  logic [W-1:0]           y;
  logic [1:0]             nrd;
  logic [SW-1:0]          rd0;
  logic [SW-1:0]          rd1;
  logic [SW-1:0]          waddr;
  logic [W-1:0]           wd0;
  logic [W-1:0]           wd1;
  logic [W-1:0]           wd2;
  logic [1:0]             wn;
  logic [1:0]             wcnt;
  logic [1:0]             fault;
  logic [W-1:0]           topval;
  logic                   div_neg;
  logic                   div_zero;
  logic [10:0]            o_pc;
  logic [12:0]            o_top;
  logic [11:0]            o_base;
  logic [W-1:0]           o_val;
  logic                   o_halt;
  logic [1:0]             o_fault;

  logic                   mem_we;
  logic [SW-1:0]          mem_waddr;
  logic [W-1:0]           mem_wdata;
  logic                   mem_re;
  logic [SW-1:0]          mem_raddr;
  logic [W-1:0]           mem_rdata;
  logic                   mem_busy;
  logic                   div_start;
  logic [W-1:0]           div_q;
  psm_pkg::div_stat_t     div_stat;

  logic signed [IW-1:0]   tx;
  logic signed [IW-1:0]   bx;
  logic signed [IW-1:0]   ax;
  logic [PW-1:0]          pc_seq;
  logic [3:0]             lvl_sat;
  logic                   is_bin;
  logic                   e_bad;
  logic [1:0]             e_nrd;
  logic signed [IW-1:0]   e_rd0;
  logic signed [IW-1:0]   e_rd1;
  logic signed [IW-1:0]   nb_x;

  assign tx      = IW'(top);
  assign bx      = IW'(signed'({1'b0, base}));
  assign ax      = IW'(signed'({1'b0, opa}));
  assign pc_seq  = (pc == PW'(PROGRAM_WORDS - 1)) ? '0 : pc + 1'b1;
  assign lvl_sat = ({2'b00, s_tdata[4:3]} > 4'(MAX_LEVEL)) ? 4'(MAX_LEVEL)
                                                           : {2'b00, s_tdata[4:3]};
  assign is_bin  = (opa inside {[psm_pkg::OPR_ADD:psm_pkg::OPR_DIV],
                                [psm_pkg::OPR_EQ:psm_pkg::OPR_LE]});
  assign nb_x    = IW'(signed'(x));
  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {1'b0, o_fault, o_halt, o_val, o_base, o_top, o_pc};

  // Index checks and read addresses once the base chain is resolved.
  always_comb begin
    e_bad = 1'b0;
    e_nrd = 2'd0;
    e_rd0 = tx;
    e_rd1 = tx;
    case (mode)
      psm_pkg::MODE_LIT: e_bad = !ix_ok(tx + 1);
      psm_pkg::MODE_OPR: begin
        if (opa == psm_pkg::OPR_RET) begin
          e_bad = !ix_ok(bx + 1) || !ix_ok(bx + 2);
          e_nrd = 2'd2;
          e_rd0 = bx + 1;
          e_rd1 = bx + 2;
        end else if (opa == psm_pkg::OPR_NEG || opa == psm_pkg::OPR_ODD) begin
          e_bad = !ix_ok(tx);
          e_nrd = 2'd1;
        end else if (is_bin) begin
          e_bad = !ix_ok(tx) || !ix_ok(tx - 1);
          e_nrd = 2'd2;
          e_rd0 = tx - 1;
        end
      end
      psm_pkg::MODE_LOD: begin
        e_bad = !ix_ok(bl + ax) || !ix_ok(tx + 1);
        e_nrd = 2'd1;
        e_rd0 = bl + ax;
      end
      psm_pkg::MODE_STO: begin
        e_bad = !ix_ok(bl + ax) || !ix_ok(tx);
        e_nrd = 2'd1;
      end
      psm_pkg::MODE_CAL: e_bad = !ix_ok(tx + 1) || !ix_ok(tx + 3);
      psm_pkg::MODE_INT: e_bad = (tx + ax) > (DEPTH_S - 1);
      psm_pkg::MODE_JPC: begin
        e_bad = !ix_ok(tx);
        e_nrd = 2'd1;
      end
      default: e_bad = 1'b0;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = waddr + SW'(wcnt);
    mem_wdata = wd0;
    mem_re    = 1'b0;
    mem_raddr = rd0;
    div_start = 1'b0;
    case (state)
      S_WALK: begin
        mem_re    = (lvl_cnt != 4'd0) && ix_ok(bl);
        mem_raddr = bl[SW-1:0];
      end
      S_RD0: mem_re = 1'b1;
      S_RD1: begin
        mem_re    = (nrd == 2'd2);
        mem_raddr = rd1;
      end
      S_ALU: div_start = (mode == psm_pkg::MODE_OPR) && (opa == psm_pkg::OPR_DIV);
      S_WR: begin
        mem_we = 1'b1;
        case (wcnt)
          2'd1:    mem_wdata = wd1;
          2'd2:    mem_wdata = wd2;
          default: mem_wdata = wd0;
        endcase
      end
      S_TOP: begin
        mem_re    = ix_ok(tx);
        mem_raddr = top[SW-1:0];
      end
      default: mem_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      top      <= '1;
      base     <= '0;
      pc       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (!mem_busy) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            mode    <= s_tdata[2:0];
            opa     <= s_tdata[15:5];
            bl      <= bx;
            fault   <= psm_pkg::FAULT_NONE;
            wn      <= 2'd0;
            wcnt    <= 2'd0;
            lvl_cnt <= (s_tdata[2:0] inside {psm_pkg::MODE_LOD, psm_pkg::MODE_STO,
                                             psm_pkg::MODE_CAL}) ? lvl_sat : 4'd0;
            state   <= S_WALK;
          end
        end
        S_WALK: begin
          if (lvl_cnt == 4'd0) begin
            state <= S_EXEC;
          end else if (!ix_ok(bl)) begin
            state <= S_FAULT;
          end else begin
            state <= S_WALKW;
          end
        end
        S_WALKW: begin
          bl      <= IW'(signed'(mem_rdata));
          lvl_cnt <= lvl_cnt - 1'b1;
          state   <= S_WALK;
        end
        S_EXEC: begin
          nrd <= e_nrd;
          rd0 <= e_rd0[SW-1:0];
          rd1 <= e_rd1[SW-1:0];
          if (e_bad) begin
            state <= S_FAULT;
          end else if (e_nrd != 2'd0) begin
            state <= S_RD0;
          end else begin
            state <= S_ALU;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          x     <= mem_rdata;
          state <= (nrd == 2'd2) ? S_RD2 : S_ALU;
        end
        S_RD2: begin
          y     <= mem_rdata;
          state <= S_ALU;
        end
        S_ALU: begin
          pc    <= pc_seq;
          state <= S_TOP;
          case (mode)
            psm_pkg::MODE_LIT: begin
              top   <= top + 1'b1;
              waddr <= SW'(top + 1'b1);
              wd0   <= W'(opa);
              wn    <= 2'd1;
              state <= S_WR;
            end
            psm_pkg::MODE_OPR: begin
              if (opa == psm_pkg::OPR_RET) begin
                if (!ix_ok(nb_x)) begin
                  fault <= psm_pkg::FAULT_STACK;
                end else begin
                  top  <= (SW+1)'(signed'({1'b0, base})) - 1'b1;
                  base <= nb_x[SW-1:0];
                  pc   <= PW'(y);
                end
              end else if (opa == psm_pkg::OPR_NEG || opa == psm_pkg::OPR_ODD) begin
                waddr <= top[SW-1:0];
                wd0   <= (opa == psm_pkg::OPR_NEG) ? -x : {{(W-1){1'b0}}, x[0]};
                wn    <= 2'd1;
                state <= S_WR;
              end else if (is_bin) begin
                top   <= top - 1'b1;
                waddr <= SW'(top - 1'b1);
                wn    <= 2'd1;
                state <= S_WR;
                case (opa)
                  psm_pkg::OPR_ADD: wd0 <= y + x;
                  psm_pkg::OPR_SUB: wd0 <= x - y;
                  psm_pkg::OPR_MUL: wd0 <= x * y;
                  psm_pkg::OPR_EQ:  wd0 <= W'(x == y);
                  psm_pkg::OPR_NE:  wd0 <= W'(x != y);
                  psm_pkg::OPR_LT:  wd0 <= W'($signed(x) < $signed(y));
                  psm_pkg::OPR_GE:  wd0 <= W'($signed(x) >= $signed(y));
                  psm_pkg::OPR_GT:  wd0 <= W'($signed(x) > $signed(y));
                  psm_pkg::OPR_LE:  wd0 <= W'($signed(x) <= $signed(y));
                  default: begin
                    div_neg  <= x[W-1] ^ y[W-1];
                    div_zero <= (y == '0);
                    if (y == '0) begin
                      fault <= psm_pkg::FAULT_DIV0;
                    end
                    state <= S_DIVW;
                  end
                endcase
              end
            end
            psm_pkg::MODE_LOD: begin
              top   <= top + 1'b1;
              waddr <= SW'(top + 1'b1);
              wd0   <= x;
              wn    <= 2'd1;
              state <= S_WR;
            end
            psm_pkg::MODE_STO: begin
              top   <= top - 1'b1;
              waddr <= SW'(bl + ax);
              wd0   <= x;
              wn    <= 2'd1;
              state <= S_WR;
            end
            psm_pkg::MODE_CAL: begin
              waddr <= SW'(top + 1'b1);
              wd0   <= W'(bl);
              wd1   <= W'(base);
              wd2   <= W'(pc_seq);
              wn    <= 2'd3;
              base  <= SW'(top + 1'b1);
              pc    <= PW'(opa);
              state <= S_WR;
            end
            psm_pkg::MODE_INT: top <= (SW+1)'(tx + ax);
            psm_pkg::MODE_JMP: pc <= PW'(opa);
            default: begin
              if (x != '0) begin
                pc <= PW'(opa);
              end
              top <= top - 1'b1;
            end
          endcase
        end
        S_DIVW: begin
          if (div_stat.done) begin
            wd0   <= div_zero ? '0 : (div_neg ? -div_q : div_q);
            state <= S_WR;
          end
        end
        S_WR: begin
          wcnt <= wcnt + 1'b1;
          if (wcnt == wn - 1'b1) begin
            state <= S_TOP;
          end
        end
        S_FAULT: begin
          fault <= psm_pkg::FAULT_STACK;
          pc    <= pc_seq;
          state <= S_TOP;
        end
        S_TOP: begin
          topval <= '0;
          state  <= ix_ok(tx) ? S_TOPW : S_DONE;
        end
        S_TOPW: begin
          topval <= mem_rdata;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            o_pc     <= 11'(pc);
            o_top    <= tx[12:0];
            o_base   <= bx[11:0];
            o_val    <= topval;
            o_halt   <= (pc == '0);
            o_fault  <= fault;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  psm_stack_mem #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  psm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (x[W-1] ? -x : x),
    .divisor  (y[W-1] ? -y : y),
    .quotient (div_q),
    .stat     (div_stat)
  );

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !mem_busy)
    else $error("instruction taken during stack clear");

  a_div_running: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVW) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on an idle divider");

  a_write_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> (wcnt < wn))
    else $error("write sequence overran");
endmodule
`default_nettype wire

>>> sim/pcode_stack_machine_step_tb.sv
// ---------------------------------------------------------------------------
// pcode_stack_machine_step_tb: self-checking bench for the p-code machine step
// Feeds a directed instruction list and then random instructions and call
// frames, predicts every step on a private stack copy, and checks each result
// transfer field by field under changing sender and receiver idling.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
module pcode_stack_machine_step_tb;

  localparam int DEPTH = 4096;
  localparam int PWORDS = 2048;
  localparam int MAXLVL = 3;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    bit          pause;
    bit          hold;
    int          phase;
    logic [15:0] data;
  } instr_t;

  typedef struct {
    logic [10:0] pc;
    logic [12:0] top;
    logic [11:0] base;
    logic [31:0] word;
    logic        halted;
    logic [1:0]  fault;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;

  instr_t      program_q[$];
  step_t       step_q[$];

  logic [31:0] stack_mem [DEPTH];
  longint      top_ptr;
  longint      base_ptr;
  int          pc;

  int          cur_phase;
  int          hold_reqs;
  int          hold_served;
  int          hold_cnt;
  int          errors;
  int          n_steps;
  int          n_faults;
  int          n_halts;
  int          cur_phase_seq;
  longint      depth_est;

  pcode_stack_machine_step dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  function automatic bit in_stack(longint i);
    return i >= 0 && i < DEPTH;
  endfunction

  function automatic longint sext(logic [31:0] w);
    return longint'($signed(w));
  endfunction

  // Executes one instruction on the private machine copy and queues its result.
  function automatic void execute_instr(logic [15:0] d);
    logic [2:0]  mode;
    logic [1:0]  lvl;
    logic [10:0] a;
    longint      t, b, bl, nb;
    int          np, seq_pc, k;
    logic [1:0]  flt;
    bit          bad;
    logic [31:0] x, y, r;
    step_t       s;
    mode = d[2:0];
    lvl = d[4:3];
    a = d[15:5];
    t = top_ptr;
    b = base_ptr;
    seq_pc = (pc + 1) % PWORDS;
    np = seq_pc;
    flt = psm_pkg::FAULT_NONE;
    bad = 0;
    bl = base_ptr;
    // The static-link walk is shared by loads, stores and calls.
    if (mode == psm_pkg::MODE_LOD || mode == psm_pkg::MODE_STO ||
        mode == psm_pkg::MODE_CAL) begin
      for (k = 0; k < ((lvl > MAXLVL) ? MAXLVL : lvl); k++) begin
        if (!in_stack(bl)) begin
          bad = 1;
          break;
        end
        bl = sext(stack_mem[bl]);
      end
    end
    case (mode)
      psm_pkg::MODE_LIT: begin
        if (!in_stack(t + 1)) bad = 1;
        else begin
          t++;
          stack_mem[t] = 32'(a);
        end
      end
      psm_pkg::MODE_OPR: begin
        if (a == psm_pkg::OPR_RET) begin
          if (!in_stack(b + 1) || !in_stack(b + 2)) bad = 1;
          else begin
            nb = sext(stack_mem[b + 1]);
            if (!in_stack(nb)) bad = 1;
            else begin
              np = stack_mem[b + 2] % PWORDS;
              t = b - 1;
              b = nb;
            end
          end
        end else if (a == psm_pkg::OPR_NEG || a == psm_pkg::OPR_ODD) begin
          if (!in_stack(t)) bad = 1;
          else stack_mem[t] = (a == psm_pkg::OPR_NEG) ? -stack_mem[t]
                                                      : {31'd0, stack_mem[t][0]};
        end else if ((a >= psm_pkg::OPR_ADD && a <= psm_pkg::OPR_DIV) ||
                     (a >= psm_pkg::OPR_EQ && a <= psm_pkg::OPR_LE)) begin
          if (!in_stack(t) || !in_stack(t - 1)) bad = 1;
          else begin
            x = stack_mem[t - 1];
            y = stack_mem[t];
            case (a)
              psm_pkg::OPR_ADD: r = x + y;
              psm_pkg::OPR_SUB: r = x - y;
              psm_pkg::OPR_MUL: r = x * y;
              psm_pkg::OPR_DIV: begin
                if (y == 0) begin
                  flt = psm_pkg::FAULT_DIV0;
                  r = 0;
                end else r = 32'(sext(x) / sext(y));
              end
              psm_pkg::OPR_EQ:  r = 32'(sext(x) == sext(y));
              psm_pkg::OPR_NE:  r = 32'(sext(x) != sext(y));
              psm_pkg::OPR_LT:  r = 32'(sext(x) < sext(y));
              psm_pkg::OPR_GE:  r = 32'(sext(x) >= sext(y));
              psm_pkg::OPR_GT:  r = 32'(sext(x) > sext(y));
              default: r = 32'(sext(x) <= sext(y));
            endcase
            t--;
            stack_mem[t] = r;
          end
        end
      end
      psm_pkg::MODE_LOD: begin
        if (bad || !in_stack(bl + a) || !in_stack(t + 1)) bad = 1;
        else begin
          t++;
          stack_mem[t] = stack_mem[bl + a];
        end
      end
      psm_pkg::MODE_STO: begin
        if (bad || !in_stack(bl + a) || !in_stack(t)) bad = 1;
        else begin
          stack_mem[bl + a] = stack_mem[t];
          t--;
        end
      end
      psm_pkg::MODE_CAL: begin
        if (bad || !in_stack(t + 1) || !in_stack(t + 3)) bad = 1;
        else begin
          stack_mem[t + 1] = 32'(bl);
          stack_mem[t + 2] = 32'(b);
          stack_mem[t + 3] = 32'(np);
          b = t + 1;
          np = a % PWORDS;
        end
      end
      psm_pkg::MODE_INT: begin
        // The sum stays signed so that an empty stack reserves correctly.
        if (t + longint'(a) > DEPTH - 1) bad = 1;
        else t += longint'(a);
      end
      psm_pkg::MODE_JMP: np = a % PWORDS;
      default: begin
        if (!in_stack(t)) bad = 1;
        else begin
          if (stack_mem[t] != 0) np = a % PWORDS;
          t--;
        end
      end
    endcase
    if (bad) begin
      flt = psm_pkg::FAULT_STACK;
      np = seq_pc;
    end else begin
      top_ptr = t;
      base_ptr = b;
    end
    pc = np;
    s.pc = 11'(pc);
    s.top = 13'(top_ptr);
    s.base = 12'(base_ptr);
    s.word = in_stack(top_ptr) ? stack_mem[top_ptr] : 32'd0;
    s.halted = (pc == 0);
    s.fault = flt;
    if (flt != psm_pkg::FAULT_NONE) n_faults++;
    if (pc == 0) n_halts++;
    n_steps++;
    step_q.push_back(s);
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("ERROR %0t: %s got %0h expected %0h", $realtime, field, got, want);
    errors++;
  endtask

  task automatic add_instr(logic [2:0] mode, logic [1:0] lvl, logic [10:0] a);
    instr_t it;
    it.pause = 0;
    it.hold = 0;
    it.phase = cur_phase_seq;
    it.data = {a, lvl, mode};
    program_q.push_back(it);
  endtask

  task automatic add_marker(bit pause, bit hold);
    instr_t it;
    it.pause = pause;
    it.hold = hold;
    it.phase = cur_phase_seq;
    it.data = '0;
    program_q.push_back(it);
  endtask

  function automatic logic [10:0] rand_binop();
    case ($urandom_range(0, 9))
      0: return psm_pkg::OPR_ADD;
      1: return psm_pkg::OPR_SUB;
      2: return psm_pkg::OPR_MUL;
      3: return psm_pkg::OPR_DIV;
      4: return psm_pkg::OPR_EQ;
      5: return psm_pkg::OPR_NE;
      6: return psm_pkg::OPR_LT;
      7: return psm_pkg::OPR_GE;
      8: return psm_pkg::OPR_GT;
      default: return psm_pkg::OPR_LE;
    endcase
  endfunction

  // A well-formed procedure call: frame, locals, work, return.
  task automatic add_call_frame();
    add_instr(psm_pkg::MODE_CAL, 2'($urandom_range(0, 1)), 11'($urandom));
    add_instr(psm_pkg::MODE_INT, 2'($urandom), 11'($urandom_range(3, 6)));
    add_instr(psm_pkg::MODE_LIT, 2'($urandom), 11'($urandom));
    add_instr(psm_pkg::MODE_LOD, 2'($urandom_range(0, 1)), 11'($urandom_range(0, 4)));
    add_instr(psm_pkg::MODE_OPR, 2'($urandom), rand_binop());
    add_instr(psm_pkg::MODE_STO, 2'd0, 11'($urandom_range(3, 5)));
    add_instr(psm_pkg::MODE_LOD, 2'd0, 11'($urandom_range(0, 5)));
    if ($urandom_range(0, 1)) add_instr(psm_pkg::MODE_OPR, 2'($urandom), psm_pkg::OPR_ODD);
    add_instr(psm_pkg::MODE_OPR, 2'($urandom), psm_pkg::OPR_RET);
  endtask

  task automatic add_random_instr();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 24) begin
      add_instr(psm_pkg::MODE_LIT, 2'($urandom), 11'($urandom));
      depth_est++;
    end else if (pick < 42) begin
      add_instr(psm_pkg::MODE_OPR, 2'($urandom), rand_binop());
      depth_est--;
    end else if (pick < 48) begin
      add_instr(psm_pkg::MODE_OPR, 2'($urandom),
                $urandom_range(0, 1) ? psm_pkg::OPR_NEG : psm_pkg::OPR_ODD);
    end else if (pick < 51) begin
      // Unknown operator codes.
      add_instr(psm_pkg::MODE_OPR, 2'($urandom),
                $urandom_range(0, 1) ? 11'd7
                                     : 11'($urandom_range(psm_pkg::OPR_LE + 1, 2047)));
    end else if (pick < 61) begin
      add_instr(psm_pkg::MODE_LOD, 2'($urandom),
                $urandom_range(0, 9) ? 11'($urandom_range(0, 12)) : 11'($urandom));
      depth_est++;
    end else if (pick < 70) begin
      add_instr(psm_pkg::MODE_STO, 2'($urandom),
                $urandom_range(0, 9) ? 11'($urandom_range(0, 12)) : 11'($urandom));
      depth_est--;
    end else if (pick < 76) begin
      add_instr(psm_pkg::MODE_JPC, 2'($urandom), 11'($urandom));
      depth_est--;
    end else if (pick < 80) begin
      add_instr(psm_pkg::MODE_JMP, 2'($urandom),
                $urandom_range(0, 7) ? 11'($urandom) : 11'd0);
    end else if (pick < 84) begin
      add_instr(psm_pkg::MODE_INT, 2'($urandom),
                $urandom_range(0, 19) ? 11'($urandom_range(0, 3)) : 11'($urandom));
    end else if (pick < 88) begin
      add_instr(psm_pkg::MODE_OPR, 2'($urandom), psm_pkg::OPR_RET);
    end else begin
      add_call_frame();
    end
    if (depth_est < 0) depth_est = 0;
  endtask

  // Sender: offers queued instructions and tracks the active idling phase.
  always @(posedge clk) begin
    int  idle_pct;
    bit  offered;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_tready) execute_instr(s_tdata);
      if (!s_tvalid || s_tready) begin
        offered = 0;
        while (program_q.size() > 0 && (program_q[0].pause || program_q[0].hold)) begin
          if (program_q[0].pause && step_q.size() != 0) break;
          if (program_q[0].hold) hold_reqs++;
          void'(program_q.pop_front());
        end
        if (program_q.size() > 0 && !program_q[0].pause) begin
          cur_phase = program_q[0].phase;
          idle_pct = (cur_phase == 1) ? 55 : (cur_phase == 3) ? 20 : 0;
          if ($urandom_range(0, 99) >= idle_pct) begin
            s_tdata <= program_q[0].data;
            void'(program_q.pop_front());
            offered = 1;
          end
        end
        s_tvalid <= offered;
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request.
  always @(posedge clk) begin
    int stall_pct;
    step_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (step_q.size() == 0) begin
          $display("ERROR %0t: result transfer with nothing expected", $realtime);
          errors++;
        end else begin
          e = step_q.pop_front();
          if (m_tdata[10:0] !== e.pc) report_mismatch("next_pc", m_tdata[10:0], e.pc);
          if (m_tdata[23:11] !== e.top) report_mismatch("top_index", m_tdata[23:11], e.top);
          if (m_tdata[35:24] !== e.base) report_mismatch("base_index", m_tdata[35:24], e.base);
          if (m_tdata[67:36] !== e.word) report_mismatch("top_value", m_tdata[67:36], e.word);
          if (m_tdata[68] !== e.halted) report_mismatch("halted", m_tdata[68], e.halted);
          if (m_tdata[70:69] !== e.fault) report_mismatch("fault", m_tdata[70:69], e.fault);
        end
      end
      stall_pct = (cur_phase == 2) ? 55 : (cur_phase == 3) ? 20 : 0;
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else if (hold_served < hold_reqs) begin
        hold_served++;
        hold_cnt = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    #15ms;
    $display("pcode_stack_machine_step_tb NOT OK");
    $finish;
  end

  initial begin
    int p;
    errors = 0;
    n_steps = 0;
    n_faults = 0;
    n_halts = 0;
    hold_reqs = 0;
    hold_served = 0;
    hold_cnt = 0;
    cur_phase = 0;
    cur_phase_seq = 0;
    depth_est = 0;
    top_ptr = -1;
    base_ptr = 0;
    pc = 0;
    foreach (stack_mem[i]) stack_mem[i] = '0;

    // Directed: stack limits, return to the bottom frame, empty-stack pops,
    // divide by zero, signed divide, odd, jumps and deep walks.
    add_instr(psm_pkg::MODE_LIT, 2'd0, 11'd5);
    add_instr(psm_pkg::MODE_LIT, 2'd0, 11'd0);
    add_instr(psm_pkg::MODE_LIT, 2'd0, 11'd9);
    add_instr(psm_pkg::MODE_INT, 2'd0, 11'd2047);
    add_instr(psm_pkg::MODE_INT, 2'd0, 11'd2047);
    add_instr(psm_pkg::MODE_LIT, 2'd3, 11'd2047);
    add_instr(psm_pkg::MODE_LIT, 2'd0, 11'd1);
    add_instr(psm_pkg::MODE_LIT, 2'd0, 11'd2);
    add_instr(psm_pkg::MODE_INT, 2'd0, 11'd1);
    add_instr(psm_pkg::MODE_OPR, 2'd0, psm_pkg::OPR_RET);
    add_instr(psm_pkg::MODE_OPR, 2'd0, psm_pkg::OPR_ADD);
    add_instr(psm_pkg::MODE_JPC, 2'd0, 11'd3);
    add_instr(psm_pkg::MODE_STO, 2'd0, 11'd0);
    add_instr(psm_pkg::MODE_OPR, 2'd0, psm_pkg::OPR_NEG);
    add_instr(psm_pkg::MODE_LIT, 2'd0, 11'd2047);
    add_instr(psm_pkg::MODE_LIT, 2'd0, 11'd0);
    add_instr(psm_pkg::MODE_OPR, 2'd0, psm_pkg::OPR_DIV);
    add_instr(psm_pkg::MODE_LIT, 2'd0, 11'd7);
    add_instr(psm_pkg::MODE_OPR, 2'd0, psm_pkg::OPR_NEG);
    add_instr(psm_pkg::MODE_LIT, 2'd0, 11'd2);
    add_instr(psm_pkg::MODE_OPR, 2'd0, psm_pkg::OPR_DIV);
    add_instr(psm_pkg::MODE_OPR, 2'd0, psm_pkg::OPR_ODD);
    add_instr(psm_pkg::MODE_LOD, 2'd3, 11'd2047);
    add_instr(psm_pkg::MODE_JPC, 2'd0, 11'd2047);
    add_instr(psm_pkg::MODE_JMP, 2'd0, 11'd0);

    for (p = 0; p < 4; p++) begin
      cur_phase_seq = p;
      // A sender pause that lets every outstanding result drain.
      add_marker(1'b1, 1'b0);
      if (p == 0) add_marker(1'b0, 1'b1);
      while (program_q.size() < 25 + (p + 1) * 460) add_random_instr();
    end
    // A last stretch without random idling, behind a long receiver hold-off.
    cur_phase_seq = 0;
    add_marker(1'b0, 1'b1);
    while (program_q.size() < 1880) add_random_instr();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (program_q.size() != 0 || s_tvalid || step_q.size() != 0);
    repeat (60) @(posedge clk);

    $display("Ran %0d instructions: %0d faulting steps, %0d halting steps,", n_steps,
             n_faults, n_halts);
    $display("with call frames, stack limits and four idling mixes plus a long hold-off.");
    if (errors == 0 && step_q.size() == 0) begin
      $display("pcode_stack_machine_step_tb OK");
    end else begin
      $display("pcode_stack_machine_step_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
src/psm_pkg.sv
src/psm_stack_mem.sv
src/psm_div.sv
src/pcode_stack_machine_step.sv
sim/pcode_stack_machine_step_tb.sv
